[rtl/btbt_pkg.sv]
// btbt_pkg: shared types, constants and helper functions for the branch target buffer
// with tournament predictor; no dependencies, imported by every rtl module
`default_nettype none

package btbt_pkg;

  // number of buffer lines, a power of two so the line index is the low pc bits
  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);

  // mode register codes
  localparam logic [1:0] MODE_LOCAL  = 2'd0;
  localparam logic [1:0] MODE_GLOBAL = 2'd1;
  localparam logic [1:0] MODE_TOURN  = 2'd2;

  // action codes
  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // 2-bit predictor and selector states
  localparam logic [1:0] ST2_00 = 2'b00;
  localparam logic [1:0] ST2_01 = 2'b01;
  localparam logic [1:0] ST2_10 = 2'b10;
  localparam logic [1:0] ST2_11 = 2'b11;

  // one buffer line
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] target;
    logic [1:0]  local_st;
    logic [7:0]  global_st;
    logic [1:0]  sel_st;
  } line_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } dp_sts_t;

  // predictor transition: not a saturating counter
  function automatic logic [1:0] next_pred(input logic [1:0] s, input logic taken);
    logic [1:0] r;
    if (taken) begin
      r = (s == ST2_00) ? ST2_01 : ST2_11;
    end else begin
      r = (s == ST2_11) ? ST2_10 : ST2_00;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/btbt_ctrl.sv]
// btbt_ctrl: sequencing state machine (clearing pass, accept, evaluate and commit)
// depends on btbt_pkg
`default_nettype none

module btbt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire btbt_pkg::dp_sts_t  sts,
  output btbt_pkg::ctl_cmd_t      cmd
);
  import btbt_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      FSM_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        // wait here while the previous result is still unclaimed
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/btbt_dp.sv]
// btbt_dp: line memory, input latch, prediction and training logic, history,
// mode register and output register; depends on btbt_pkg
`default_nettype none

module btbt_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire btbt_pkg::ctl_cmd_t cmd,
  output btbt_pkg::dp_sts_t       sts,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_wr_data,
  input  wire logic               in_action,
  input  wire logic [31:0]        in_branch_pc,
  input  wire logic [31:0]        in_branch_target,
  input  wire logic               in_actual_taken,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_hit,
  output logic                    out_predict_taken,
  output logic [31:0]             out_predicted_target,
  output logic                    out_collision
);
  import btbt_pkg::*;

  line_t mem [ENTRIES];
  line_t rd_line_r;

  logic [IDX_W-1:0] clr_idx_r;
  logic [1:0]       mode_r;
  logic [1:0]       hist_r;

  logic        action_r;
  logic [31:0] pc_r;
  logic [31:0] tgt_r;
  logic        taken_r;

  logic        out_valid_r;
  logic        out_hit_r;
  logic        out_ptaken_r;
  logic [31:0] out_ptarget_r;
  logic        out_coll_r;

  // evaluation
  logic             hit, coll, lp, gp, ptaken, lok, gok, mem_we;
  logic [1:0]       gs, sel_nxt;
  logic [7:0]       gall_nxt;
  line_t            wr_line;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    hit  = rd_line_r.valid && (rd_line_r.tag == pc_r);
    coll = rd_line_r.valid && (rd_line_r.tag != pc_r);
    gs   = rd_line_r.global_st[{hist_r, 1'b0} +: 2];
    lp   = rd_line_r.local_st[1];
    gp   = gs[1];
    unique case (mode_r)
      MODE_LOCAL:  ptaken = lp;
      MODE_GLOBAL: ptaken = gp;
      default:     ptaken = rd_line_r.sel_st[1] ? lp : gp;
    endcase

    lok = (lp == taken_r);
    gok = (gp == taken_r);
    sel_nxt = rd_line_r.sel_st;
    if (lok && !gok && rd_line_r.sel_st != ST2_11) begin
      sel_nxt = rd_line_r.sel_st + 2'd1;
    end else if (!lok && gok && rd_line_r.sel_st != ST2_00) begin
      sel_nxt = rd_line_r.sel_st - 2'd1;
    end
    gall_nxt = rd_line_r.global_st;
    gall_nxt[{hist_r, 1'b0} +: 2] = next_pred(gs, taken_r);

    wr_line = rd_line_r;
    if (cmd.clr_wr) begin
      wr_line = '0;
    end else if (!hit) begin
      wr_line.valid     = 1'b1;
      wr_line.tag       = pc_r;
      wr_line.target    = tgt_r;
      wr_line.sel_st    = ST2_10;
      wr_line.local_st  = ST2_11;
      wr_line.global_st = {4{ST2_11}};
    end else begin
      wr_line.sel_st    = sel_nxt;
      wr_line.local_st  = next_pred(rd_line_r.local_st, taken_r);
      wr_line.global_st = gall_nxt;
      if (taken_r) begin
        wr_line.target = tgt_r;
      end
    end
    wr_idx = cmd.clr_wr ? clr_idx_r : pc_r[IDX_W-1:0];
    mem_we = cmd.clr_wr || (cmd.commit && action_r == ACT_UPDATE);
  end

  // line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_line;
    end
    if (cmd.accept) begin
      rd_line_r <= mem[in_branch_pc[IDX_W-1:0]];
    end
  end

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      pc_r     <= in_branch_pc;
      tgt_r    <= in_branch_target;
      taken_r  <= in_actual_taken;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      mode_r      <= MODE_TOURN;
      hist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.commit && action_r == ACT_UPDATE) begin
        hist_r <= {hist_r[0], taken_r};
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r     <= hit;
      out_coll_r    <= coll;
      out_ptaken_r  <= (action_r == ACT_QUERY) && hit && ptaken;
      out_ptarget_r <= ((action_r == ACT_QUERY) && hit) ? rd_line_r.target : 32'd0;
    end
  end

  assign sts.clr_last = (clr_idx_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_predict_taken    = out_ptaken_r;
  assign out_predicted_target = out_ptarget_r;
  assign out_collision        = out_coll_r;

endmodule

`default_nettype wire

[rtl/btb_tournament_branch_predictor_top.sv]
// btb_tournament_branch_predictor_top: top level, joins controller and datapath
// depends on btbt_pkg, btbt_ctrl and btbt_dp
`default_nettype none

// Direct-mapped branch target buffer of ENTRIES (1024) lines indexed by the low pc
// bits, each line holding a valid bit, the full pc tag, a target, a local 2-bit
// predictor, four global 2-bit predictors picked by a 2-bit outcome history and a
// 2-bit selector. A word with action 0 is a query (hit, direction, stored target;
// a miss reports not taken and target 0); action 1 is an update that replaces the
// line on a miss or trains it on a hit, then shifts the outcome into the history.
// A word is handled in steps: the cycle in which it is accepted does the registered
// read of the line memory (one write port, one registered read port), then the exec
// state evaluates, writes the line back and loads the output register, and out_valid
// rises when that register is loaded; no new word is accepted until then. The exec
// state stretches while the previous result still waits on out_ready; the output
// register lets the next word be accepted while a committed result still waits.
// After reset, in_ready stays low while the valid bits are cleared line by line; mode writes
// are taken during that pass. cfg_wr_data selects local (0), global (1) or
// tournament (2, and 3) prediction; reset value is tournament.

module btb_tournament_branch_predictor_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_branch_pc,
  input  wire logic [31:0] in_branch_target,
  input  wire logic        in_actual_taken,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic             out_predict_taken,
  output logic [31:0]      out_predicted_target,
  output logic             out_collision
);
  import btbt_pkg::*;

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: clearing pass, accept, then commit once the result slot is free
  btbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: line memory, prediction and training, history and result register
  btbt_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_action            (in_action),
    .in_branch_pc         (in_branch_pc),
    .in_branch_target     (in_branch_target),
    .in_actual_taken      (in_actual_taken),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit              (out_hit),
    .out_predict_taken    (out_predict_taken),
    .out_predicted_target (out_predicted_target),
    .out_collision        (out_collision)
  );

endmodule

`default_nettype wire

[sim/btbt_lookup_checker.sv]
`timescale 1ns / 1ps
// btbt_lookup_checker: watches the mode port and both word channels of the branch target
// buffer, keeps its own copy of the lines and history, and compares every result word.
// depends on btbt_pkg for sizes and codes
module btbt_lookup_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_action,
  input  logic [31:0]       in_branch_pc,
  input  logic [31:0]       in_branch_target,
  input  logic              in_actual_taken,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_hit,
  input  logic              out_predict_taken,
  input  logic [31:0]       out_predicted_target,
  input  logic              out_collision,
  output int unsigned       fail_count,
  output int unsigned       words_in_flight
);
  import btbt_pkg::*;

  typedef struct packed {
    logic        hit;
    logic        taken;
    logic [31:0] target;
    logic        collision;
  } lookup_t;

  logic        line_valid [ENTRIES];
  logic [31:0] line_tag [ENTRIES];
  logic [31:0] line_target [ENTRIES];
  logic [1:0]  line_local [ENTRIES];
  logic [7:0]  line_global [ENTRIES];
  logic [1:0]  line_sel [ENTRIES];
  logic [1:0]  outcome_hist;
  logic [1:0]  mode;

  lookup_t expected_lookups[$];
  lookup_t got_word;
  lookup_t want_word;

  initial begin
    fail_count = 0;
    words_in_flight = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40) begin
      $display("%0t mismatch on %s: got %h expected %h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // 2-bit direction state: taken climbs 00->01->11 (10 jumps to 11), not taken drops
  function automatic logic [1:0] advance_state(input logic [1:0] s, input logic tk);
    logic [1:0] n;
    case (s)
      ST2_00:  n = tk ? ST2_01 : ST2_00;
      ST2_01:  n = tk ? ST2_11 : ST2_00;
      ST2_10:  n = tk ? ST2_11 : ST2_00;
      default: n = tk ? ST2_11 : ST2_10;
    endcase
    return n;
  endfunction

  // works out the result word and applies any update to the line copy
  function automatic lookup_t predict_lookup(input logic act, input logic [31:0] pc,
                                             input logic [31:0] tgt, input logic tk);
    lookup_t r;
    logic [IDX_W-1:0] i;
    logic [1:0] loc;
    logic [1:0] glb;
    logic [1:0] sel;
    logic loc_ok;
    logic glb_ok;
    i = pc[IDX_W-1:0];
    r = '0;
    if (line_valid[i]) begin
      r.hit = (line_tag[i] == pc);
      r.collision = (line_tag[i] != pc);
    end
    if (r.hit) begin
      loc = line_local[i];
      glb = line_global[i][{outcome_hist, 1'b0} +: 2];
      sel = line_sel[i];
    end
    if (act == ACT_QUERY) begin
      if (r.hit) begin
        case (mode)
          MODE_LOCAL:  r.taken = loc[1];
          MODE_GLOBAL: r.taken = glb[1];
          default:     r.taken = sel[1] ? loc[1] : glb[1];
        endcase
        r.target = line_target[i];
      end
    end else begin
      if (!r.hit) begin
        line_valid[i] = 1'b1;
        line_tag[i] = pc;
        line_target[i] = tgt;
        line_sel[i] = ST2_10;
        line_local[i] = ST2_11;
        line_global[i] = 8'hff;
      end else begin
        loc_ok = (loc[1] == tk);
        glb_ok = (glb[1] == tk);
        if (loc_ok && !glb_ok && sel != ST2_11) begin
          sel = sel + 2'd1;
        end else if (!loc_ok && glb_ok && sel != ST2_00) begin
          sel = sel - 2'd1;
        end
        line_sel[i] = sel;
        line_local[i] = advance_state(loc, tk);
        line_global[i][{outcome_hist, 1'b0} +: 2] = advance_state(glb, tk);
        if (tk) begin
          line_target[i] = tgt;
        end
      end
      outcome_hist = {outcome_hist[0], tk};
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (line_valid[k]) line_valid[k] = 1'b0;
      outcome_hist = 2'b00;
      mode = MODE_TOURN;
      expected_lookups.delete();
    end else begin
      // results first, so a word cannot match the expectation pushed at this edge
      if (out_valid && out_ready) begin
        got_word = '{out_hit, out_predict_taken, out_predicted_target, out_collision};
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected result word", got_word.target, 32'h0);
        end else begin
          want_word = expected_lookups.pop_front();
          if (got_word.hit !== want_word.hit)
            report_mismatch("hit", 32'(got_word.hit), 32'(want_word.hit));
          if (got_word.taken !== want_word.taken)
            report_mismatch("predict_taken", 32'(got_word.taken), 32'(want_word.taken));
          if (got_word.target !== want_word.target)
            report_mismatch("predicted_target", got_word.target, want_word.target);
          if (got_word.collision !== want_word.collision)
            report_mismatch("collision", 32'(got_word.collision),
                            32'(want_word.collision));
        end
      end
      if (cfg_wr_en) begin
        mode = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        expected_lookups.push_back(predict_lookup(in_action, in_branch_pc,
                                                  in_branch_target, in_actual_taken));
      end
    end
    words_in_flight <= expected_lookups.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: stimulus and verdict for btb_tournament_branch_predictor_top
// depends on btbt_pkg, the rtl and btbt_lookup_checker
module testbench;
  import btbt_pkg::*;

  // unused mode code, the block treats it as tournament
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int POOL_SIZE = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [31:0] in_branch_pc = 32'h0;
  logic [31:0] in_branch_target = 32'h0;
  logic        in_actual_taken = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_hit;
  logic        out_predict_taken;
  logic [31:0] out_predicted_target;
  logic        out_collision;

  int unsigned fail_count;
  int unsigned words_in_flight;

  // idle odds in percent for each side, changed per phase
  int tx_idle_pct = 26;
  int rx_idle_pct = 83;

  // branch pool for the random part: half the entries share a line with the other half
  logic [31:0] pool_pc [POOL_SIZE];
  logic [31:0] pool_tgt [POOL_SIZE];
  int          pool_bias [POOL_SIZE];

  always #2 clk = ~clk;

  btb_tournament_branch_predictor_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_branch_pc         (in_branch_pc),
    .in_branch_target     (in_branch_target),
    .in_actual_taken      (in_actual_taken),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit              (out_hit),
    .out_predict_taken    (out_predict_taken),
    .out_predicted_target (out_predicted_target),
    .out_collision        (out_collision)
  );

  btbt_lookup_checker lookup_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_branch_pc         (in_branch_pc),
    .in_branch_target     (in_branch_target),
    .in_actual_taken      (in_actual_taken),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit              (out_hit),
    .out_predict_taken    (out_predict_taken),
    .out_predicted_target (out_predicted_target),
    .out_collision        (out_collision),
    .fail_count           (fail_count),
    .words_in_flight      (words_in_flight)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // present one word and hold it until taken; valid stays high for a back-to-back word
  task automatic send_word(input logic act, input logic [31:0] pc,
                           input logic [31:0] tgt, input logic tk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_branch_pc <= pc;
    in_branch_target <= tgt;
    in_actual_taken <= tk;
    do @(posedge clk); while (!in_ready);
  endtask

  // every word yields a result, so an empty expectation queue means the block is idle
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (words_in_flight != 0);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // fresh branch pool: entries k and k + POOL_SIZE/2 collide on the same line
  task automatic refill_pool;
    logic [31:0] r;
    for (int k = 0; k < POOL_SIZE; k++) begin
      r = $urandom();
      if (k >= POOL_SIZE / 2) begin
        r[IDX_W-1:0] = pool_pc[k - POOL_SIZE / 2][IDX_W-1:0];
      end
      pool_pc[k] = r;
      pool_tgt[k] = $urandom();
      case ($urandom_range(0, 2))
        0:       pool_bias[k] = 10;
        1:       pool_bias[k] = 50;
        default: pool_bias[k] = 90;
      endcase
    end
  endtask

  // mostly updates and queries on pooled branches, some words with wholly random fields
  task automatic random_words(input int count);
    int k;
    logic act;
    logic tk;
    logic [31:0] tgt;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                  1'($urandom_range(0, 1)));
      end else begin
        k = $urandom_range(0, POOL_SIZE - 1);
        act = ($urandom_range(0, 99) < 55) ? ACT_UPDATE : ACT_QUERY;
        tk = ($urandom_range(0, 99) < pool_bias[k]);
        tgt = ($urandom_range(0, 9) < 7) ? pool_tgt[k] : $urandom();
        send_word(act, pool_pc[k], tgt, tk);
      end
    end
  endtask

  initial begin
    logic [1:0] seg_mode [6];
    seg_mode = '{MODE_LOCAL, MODE_GLOBAL, MODE_TOURN, MODE_SPARE, MODE_GLOBAL, MODE_TOURN};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty line, fill, hit, collision, each predictor transition
    write_mode(MODE_TOURN);
    send_word(ACT_QUERY,  32'h0000_0000, 32'hffff_ffff, 1'b1);  // query of an empty line
    send_word(ACT_UPDATE, 32'h0000_0000, 32'hffff_ffff, 1'b1);  // miss replaces the line
    send_word(ACT_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b0);  // hit, predictor states at 11
    send_word(ACT_QUERY,  32'h0000_0400, 32'h0000_0000, 1'b0);  // same line, other tag
    send_word(ACT_UPDATE, 32'h0000_0000, 32'h1111_1111, 1'b0);  // 11 -> 10, target kept
    send_word(ACT_UPDATE, 32'h0000_0000, 32'h2222_2222, 1'b0);  // 10 -> 00
    send_word(ACT_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b1);
    send_word(ACT_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1);  // 00 -> 01, target rewritten
    send_word(ACT_UPDATE, 32'h0000_0000, 32'h8000_0001, 1'b1);  // 01 -> 11
    send_word(ACT_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(ACT_QUERY,  32'h0000_0000, 32'hffff_ffff, 1'b1);
    send_word(ACT_UPDATE, 32'hffff_ffff, 32'h0000_0000, 1'b0);  // top line, not-taken fill
    send_word(ACT_QUERY,  32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_word(ACT_UPDATE, 32'h0000_0400, 32'h1234_5678, 1'b1);  // collision evicts pc 0
    send_word(ACT_QUERY,  32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(ACT_UPDATE, 32'h0000_0400, 32'h0000_0000, 1'b0);  // drive local and global apart
    send_word(ACT_UPDATE, 32'h0000_0400, 32'h0000_0000, 1'b1);
    send_word(ACT_UPDATE, 32'h0000_0400, 32'h0000_0000, 1'b0);
    send_word(ACT_QUERY,  32'h0000_0400, 32'h0000_0000, 1'b0);
    write_mode(MODE_LOCAL);
    send_word(ACT_QUERY,  32'h0000_0400, 32'h0000_0000, 1'b0);
    write_mode(MODE_GLOBAL);
    send_word(ACT_QUERY,  32'h0000_0400, 32'h0000_0000, 1'b0);
    write_mode(MODE_SPARE);
    send_word(ACT_QUERY,  32'h0000_0400, 32'h0000_0000, 1'b0);
    send_word(ACT_QUERY,  32'hffff_ffff, 32'h0000_0000, 1'b1);

    // random: three idle regimes, two mode settings each
    for (int seg = 0; seg < 6; seg++) begin
      write_mode(seg_mode[seg]);
      if (seg == 2) begin
        tx_idle_pct = 83;
        rx_idle_pct = 26;
      end else if (seg == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      refill_pool();
      random_words(200);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[btb_tournament_branch_predictor_top.f]
rtl/btbt_pkg.sv
rtl/btbt_ctrl.sv
rtl/btbt_dp.sv
rtl/btb_tournament_branch_predictor_top.sv
sim/btbt_lookup_checker.sv
sim/testbench.sv
